// ===== rtl/core/fla_pkg.sv =====
//------------------------------------------------------------------------------
// fla_pkg: shared constants of the free list allocator
// Table geometry, page rounding constants and result status codes.
//------------------------------------------------------------------------------
`default_nettype none

package fla_pkg;

    localparam int unsigned TableEntries = 4096;
    localparam int unsigned IdxW = $clog2(TableEntries);
    localparam int unsigned CntW = 13;
    localparam int unsigned RegionW = 64;

    localparam logic [31:0] PageAdd  = 32'h0000_0fff;
    localparam logic [31:0] PageMask = 32'hffff_f000;

    localparam logic [1:0] StatusOk     = 2'd0;
    localparam logic [1:0] StatusNoFit  = 2'd1;
    localparam logic [1:0] StatusLost   = 2'd2;

    localparam logic [0:0] KindAlloc = 1'b0;
    localparam logic [0:0] KindFree  = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/fla_ram.sv =====
//------------------------------------------------------------------------------
// fla_ram: generic simple dual-port RAM
// One write and one read per cycle on separate addresses; read data registered.
//------------------------------------------------------------------------------
`default_nettype none

module fla_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/free_list_allocator.sv =====
//------------------------------------------------------------------------------
// free_list_allocator: first-fit allocator over an address-sorted free table
//
// Usage: one request beat on the s_axis group (kind, addr, size, rounding)
// gives exactly one result beat on m_axis with the allocated address, status
// and the table statistics after the request. Only one request is in
// flight: s_axis_tready is low from acceptance until the result beat has
// been taken, and the next request is taken in the idle state that follows.
// Operation: a request scans the table entry by entry (read, then
// compare). An allocate that empties its entry then shifts the later
// entries down, each by a read and a write; a free either merges in place,
// merges with both neighbours and shifts later entries down, or inserts a
// new entry and shifts the later entries up, each by a read and a write.
// The registered table read is why each entry takes a read step first.
// Reset: counters and the entry count clear at once; table contents are
// not cleared, since only entries below the count are ever used.
// Stall: a pending result is held stable until m_axis_tready is high.
//------------------------------------------------------------------------------
`default_nettype none

module free_list_allocator
    import fla_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] region_addr, [63:32] region_size
    input  wire logic [63:0]  s_axis_tdata,
    // [0] kind, [1] round_pages
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] grant_addr, [63:32] total_free, [76:64] entries_used,
    // [89:77] entries_peak, [121:90] lost_count, [153:122] lost_bytes, pad
    output logic [159:0]      m_axis_tdata,
    // [1:0] status
    output logic [1:0]        m_axis_tuser
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_CMP   = 9'b000000100,
        S_PREV  = 9'b000001000,
        S_SHRD  = 9'b000010000,
        S_SHWR  = 9'b000100000,
        S_UPRD  = 9'b001000000,
        S_UPWR  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [CntW-1:0] r_count, n_count, r_peak, n_peak;
    logic [31:0] r_lost_n, n_lost_n, r_lost_b, n_lost_b, r_total, n_total;
    logic        r_kind;
    logic [31:0] r_addr, r_size;
    logic [CntW-1:0] r_pos, n_pos;       // scan / shift cursor
    logic [CntW-1:0] r_end, n_end;       // shift boundary
    logic [RegionW-1:0] r_prev, n_prev;  // entry at pos-1 (free)
    logic [RegionW-1:0] r_hold, n_hold;  // entry carried by the shift
    logic [31:0] r_res_addr, n_res_addr;
    logic [1:0]  r_status, n_status;

    logic [31:0] size_in;

    // RAM port
    logic               we;
    logic [IdxW-1:0]    waddr, raddr;
    logic [RegionW-1:0] wdata, rdata;

    fla_ram #(.Width(RegionW), .Depth(TableEntries)) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic [31:0] rd_start, rd_len;
    logic [31:0] pv_start, pv_len;
    assign rd_start = rdata[31:0];
    assign rd_len   = rdata[63:32];
    assign pv_start = r_prev[31:0];
    assign pv_len   = r_prev[63:32];

    assign size_in = s_axis_tuser[1]
                   ? ((s_axis_tdata[63:32] + PageAdd) & PageMask)
                   : s_axis_tdata[63:32];

    logic [CntW-1:0] count_inc;
    assign count_inc = r_count + CntW'(1);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_peak = r_peak;
        n_lost_n = r_lost_n;
        n_lost_b = r_lost_b;
        n_total = r_total;
        n_pos = r_pos;
        n_end = r_end;
        n_prev = r_prev;
        n_hold = r_hold;
        n_res_addr = r_res_addr;
        n_status = r_status;
        we = 1'b0;
        waddr = r_pos[IdxW-1:0];
        wdata = rdata;
        raddr = r_pos[IdxW-1:0];
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_pos = '0;
                    n_res_addr = '0;
                    n_status = StatusOk;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                // read of entry r_pos issued here
                if (r_pos == r_count) begin
                    n_state = S_PREV;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_kind == KindAlloc[0]) begin
                    if (rd_len >= r_size) begin
                        n_res_addr = rd_start;
                        n_total = r_total - r_size;
                        we = 1'b1;
                        wdata = {rd_len - r_size, rd_start + r_size};
                        if (rd_len == r_size) begin
                            // drop emptied entry: shift later entries down
                            n_count = r_count - CntW'(1);
                            n_end = r_count - CntW'(1);
                            n_state = S_SHRD;
                        end else begin
                            n_state = S_OUT;
                        end
                    end else begin
                        n_pos = r_pos + CntW'(1);
                        n_state = S_RD;
                    end
                end else begin
                    if (rd_start > r_addr) begin
                        n_hold = rdata;
                        n_state = S_PREV;
                    end else begin
                        n_prev = rdata;
                        n_pos = r_pos + CntW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_PREV: begin
                // decide at insert point r_pos; r_hold valid if r_pos < count
                if (r_kind == KindAlloc[0]) begin
                    n_status = StatusNoFit;
                    n_state = S_OUT;
                end else if (r_pos != '0 && (pv_start + pv_len) == r_addr) begin
                    n_total = r_total + r_size;
                    we = 1'b1;
                    waddr = IdxW'(r_pos - CntW'(1));
                    if (r_pos != r_count && (r_addr + r_size) == r_hold[31:0]) begin
                        wdata = {pv_len + r_size + r_hold[63:32], pv_start};
                        n_count = r_count - CntW'(1);
                        n_end = r_count - CntW'(1);
                        n_state = S_SHRD;
                    end else begin
                        wdata = {pv_len + r_size, pv_start};
                        n_state = S_OUT;
                    end
                end else if (r_pos != r_count && (r_addr + r_size) == r_hold[31:0]) begin
                    n_total = r_total + r_size;
                    we = 1'b1;
                    wdata = {r_hold[63:32] + r_size, r_addr};
                    n_state = S_OUT;
                end else if (r_count < CntW'(TableEntries)) begin
                    n_total = r_total + r_size;
                    n_count = count_inc;
                    if (r_peak < count_inc) begin
                        n_peak = count_inc;
                    end
                    n_end = r_count;
                    n_hold = {r_size, r_addr};
                    n_state = S_UPRD;
                end else begin
                    n_lost_n = r_lost_n + 32'd1;
                    n_lost_b = r_lost_b + r_size;
                    n_status = StatusLost;
                    n_state = S_OUT;
                end
            end
            S_SHRD: begin
                // entries r_pos+1 .. r_end move to r_pos .. r_end-1
                if (r_pos >= r_end) begin
                    n_state = S_OUT;
                end else begin
                    raddr = IdxW'(r_pos + CntW'(1));
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                we = 1'b1;
                wdata = rdata;
                n_pos = r_pos + CntW'(1);
                n_state = S_SHRD;
            end
            S_UPRD: begin
                // write carried entry at r_pos, carry old one upward
                if (r_pos == r_end) begin
                    we = 1'b1;
                    wdata = r_hold;
                    n_state = S_OUT;
                end else begin
                    n_state = S_UPWR;
                end
            end
            S_UPWR: begin
                we = 1'b1;
                wdata = r_hold;
                n_hold = rdata;
                n_pos = r_pos + CntW'(1);
                raddr = IdxW'(r_pos + CntW'(1));
                n_state = S_UPRD;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_peak <= '0;
            r_lost_n <= '0;
            r_lost_b <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_peak <= n_peak;
            r_lost_n <= n_lost_n;
            r_lost_b <= n_lost_b;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_kind <= s_axis_tuser[0];
            r_addr <= s_axis_tdata[31:0];
            r_size <= size_in;
        end
        r_pos <= n_pos;
        r_end <= n_end;
        r_prev <= n_prev;
        r_hold <= n_hold;
        r_res_addr <= n_res_addr;
        r_status <= n_status;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {6'd0, r_lost_b, r_lost_n, r_peak, r_count, r_total, r_res_addr};
    assign m_axis_tuser = r_status;

    a_peak_ge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_count) else $error("peak below count");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(TableEntries)) else $error("count over table size");
    a_lost_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_status == StatusLost) |-> r_count == CntW'(TableEntries))
        else $error("loss with room in table");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(r_total)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire
